// ===== rtl/htw_pkg.sv =====
// shared types and constants for the hierarchical timer wheel
package htw_pkg;

  localparam int unsigned SLOTS_PER_LEVEL = 256;
  localparam int unsigned LVL_W           = 3;
  localparam int unsigned SLOT_W          = 8;
  localparam int unsigned PER_W           = 10;
  localparam int unsigned MAX_RESULTS     = 64;

  localparam logic [PER_W-1:0] PER_RESET      = 10'd10;
  localparam logic [31:0]      REPEAT_FOREVER = 32'h8000_0000;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [1:0] KIND_DONE    = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_QUIET   = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_BAD_ENTRY = 2'd2;
  localparam logic [1:0] STAT_NOT_ARMED = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] timer;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [31:0] reps;
    logic [31:0] period;
    logic [63:0] expiry;
  } data_t;

  typedef enum logic [5:0] {
    ST_CLR, ST_IDLE,
    ST_CR0, ST_CR1, ST_ARM_W, ST_RS_ARM,
    ST_CN0, ST_CN1, ST_REL, ST_CMD_OK, ST_FIN,
    ST_TK0, ST_DR0, ST_DR1, ST_DR2, ST_DR3, ST_DR4, ST_DR5, ST_DR6,
    ST_DR_NEXT, ST_DR_END, ST_CAS, ST_EMIT,
    ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5
  } state_t;

endpackage

// ===== rtl/htw_ram.sv =====
// generic simple dual-port ram with registered read
module htw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/htw_div.sv =====
// restoring divider, one quotient bit per cycle, hold time by tick period
module htw_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [31:0]               dividend,
  input  logic [htw_pkg::PER_W-1:0] divisor,
  output logic                      done,
  output logic [31:0]               quot
);
  import htw_pkg::*;

  logic             act_r, act_nxt;
  logic             done_r, done_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [PER_W-1:0] rem_r, rem_nxt;
  logic [PER_W-1:0] dvs_r, dvs_nxt;
  logic [31:0]      q_r, q_nxt;
  logic [PER_W:0]   sh;

  assign sh = {rem_r, q_r[31]};

  always_comb begin
    act_nxt  = act_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (start) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      q_nxt   = dividend;
      dvs_nxt = (divisor == '0) ? PER_W'(1) : divisor;
    end else if (act_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = PER_W'(sh - {1'b0, dvs_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = PER_W'(sh);
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      act_r  <= act_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/hierarchical_timer_wheel.sv =====
// hierarchical timer wheel top level: slot and entry memories and the sequencer
//
// input channel (in_valid / in_stall) takes one command per transfer: create,
// cancel, restart or tick. result channel (out_valid / out_stall) gives one
// result per command, and for a tick one result per expired timer (at most 64)
// or a single quiet result; out_last_of_run marks the final one of each run.
// cfg channel (cfg_valid / cfg_ready) writes the tick period in ms; write it
// only while the block is idle.
// the block works on one command at a time and stalls its input meanwhile.
// create and restart are dominated by the serial divider for hold time
// over tick period. a tick grows longer with each timer fired or cascaded,
// since every list edit is a read-modify-write of the slot or link memory.
// after reset a clearing pass empties all slots and builds the free list;
// input is stalled during that pass. one output register plus a one-result
// staging register let the sequencer run ahead while the receiver stalls;
// it waits only when both hold results.
module hierarchical_timer_wheel #(
  parameter int unsigned TIMER_ENTRIES = 64,
  parameter int unsigned WHEEL_LEVELS  = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [6:0]                in_timer_number,
  input  logic [31:0]               in_hold_time_ms,
  input  logic [31:0]               in_repeat_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_event_kind,
  output logic [5:0]                out_result_timer,
  output logic [1:0]                out_status,
  output logic                      out_last_of_run,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [htw_pkg::PER_W-1:0] cfg_tick_period_ms
);
  import htw_pkg::*;

  // entry pointers carry one extra code for "none"
  localparam int unsigned IW     = $clog2(TIMER_ENTRIES);
  localparam int unsigned EW     = $clog2(TIMER_ENTRIES + 1);
  localparam int unsigned SLOT_D = WHEEL_LEVELS * SLOTS_PER_LEVEL;
  localparam int unsigned SA_W   = $clog2(SLOT_D);
  localparam int unsigned CLR_N  = (SLOT_D > TIMER_ENTRIES) ? SLOT_D : TIMER_ENTRIES;
  localparam int unsigned CW     = $clog2(CLR_N + 1);
  localparam int unsigned LB     = (WHEEL_LEVELS > 1) ? $clog2(WHEEL_LEVELS) : 1;
  localparam logic [EW-1:0]    NIL     = EW'(TIMER_ENTRIES);
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(WHEEL_LEVELS - 1);

  typedef struct packed {
    logic [EW-1:0] cnt;
    logic [EW-1:0] head;
    logic [EW-1:0] tail;
  } slot_t;

  typedef struct packed {
    logic              in_use;
    logic              linked;
    logic [LVL_W-1:0]  lvl;
    logic [SLOT_W-1:0] slot;
    logic [EW-1:0]     prev;
    logic [EW-1:0]     next;
    logic [EW-1:0]     fnext;
  } link_t;

  localparam int unsigned SR_W = $bits(slot_t);
  localparam int unsigned LR_W = $bits(link_t);
  localparam int unsigned DR_W = $bits(data_t);

  // control state
  state_t           state_r, state_nxt;
  state_t           ret_r, ret_nxt;
  logic [CW-1:0]    clr_r, clr_nxt;
  logic [EW-1:0]    fhead_r, fhead_nxt;
  logic [EW-1:0]    fcnt_r, fcnt_nxt;
  logic [63:0]      now_r, now_nxt;
  logic [7:0]       cur_r [WHEEL_LEVELS];
  logic [7:0]       cur_nxt [WHEEL_LEVELS];
  logic [PER_W-1:0] per_r, per_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             stg_v_r, stg_v_nxt;
  logic [6:0]       n_r, n_nxt;

  // working registers
  logic [1:0]       op_r, op_nxt;
  logic [6:0]       num_r, num_nxt;
  logic [31:0]      hold_r, hold_nxt;
  logic [31:0]      reps_r, reps_nxt;
  logic [EW-1:0]    e_r, e_nxt;
  link_t            lk_r, lk_nxt;
  data_t            dt_r, dt_nxt;
  slot_t            sl_r, sl_nxt;
  logic [SA_W-1:0]  sa_r, sa_nxt;
  logic [SA_W-1:0]  dsa_r, dsa_nxt;
  logic [EW-1:0]    cnt_r, cnt_nxt;
  logic [63:0]      rem_r, rem_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [LVL_W-1:0] casc_r, casc_nxt;
  logic             fire_r, fire_nxt;
  res_t             stg_r, stg_nxt;
  res_t             em_r, em_nxt;
  res_t             out_r, out_nxt;
  logic             out_last_r, out_last_nxt;

  // memory ports
  logic            s_we, l_we, d_we;
  logic [SA_W-1:0] s_wa, s_ra;
  logic [IW-1:0]   l_wa, l_ra, d_wa, d_ra;
  logic [SR_W-1:0] s_wdata, s_rdata;
  logic [LR_W-1:0] l_wdata, l_rdata;
  logic [DR_W-1:0] d_wdata, d_rdata;
  slot_t           s_wd, s_rd;
  link_t           l_wd, l_rd;
  data_t           d_wd, d_rd;

  logic        div_start, div_done;
  logic [31:0] div_q;

  // filing arithmetic
  logic [63:0]       rem_calc;
  logic [LVL_W-1:0]  lv_raw, lv_cl;
  logic [63:0]       rem_sh;
  logic [8:0]        off9;
  logic [SLOT_W-1:0] offm, new_slot;
  logic              out_free;

  htw_ram #(.WIDTH(SR_W), .DEPTH(SLOT_D)) u_slot_ram (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wdata), .raddr(s_ra), .rdata(s_rdata)
  );

  htw_ram #(.WIDTH(LR_W), .DEPTH(TIMER_ENTRIES)) u_link_ram (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wdata), .raddr(l_ra), .rdata(l_rdata)
  );

  htw_ram #(.WIDTH(DR_W), .DEPTH(TIMER_ENTRIES)) u_data_ram (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wdata), .raddr(d_ra), .rdata(d_rdata)
  );

  htw_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(hold_r),
    .divisor(per_r), .done(div_done), .quot(div_q)
  );

  assign s_wdata = s_wd;
  assign l_wdata = l_wd;
  assign d_wdata = d_wd;
  assign s_rd    = slot_t'(s_rdata);
  assign l_rd    = link_t'(l_rdata);
  assign d_rd    = data_t'(d_rdata);

  // ticks left until expiry, never negative
  assign rem_calc = (dt_r.expiry > now_r) ? (dt_r.expiry - now_r) : 64'd0;

  // level: how many 256-fold bounds the remaining time exceeds
  always_comb begin
    lv_raw = '0;
    for (int i = 1; i < 8; i++) begin
      lv_raw = lv_raw + LVL_W'(rem_r > (64'd1 << (8 * i)));
    end
  end

  assign lv_cl    = (lv_raw > TOP_LVL) ? TOP_LVL : lv_raw;
  assign rem_sh   = rem_r >> {lvl_r, 3'b000};
  assign off9     = rem_sh[8:0];
  assign offm     = (off9 == 9'd0) ? '0 : SLOT_W'(off9 - 9'd1);
  assign new_slot = cur_r[lvl_r[LB-1:0]] + offm;
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    clr_nxt       = clr_r;
    fhead_nxt     = fhead_r;
    fcnt_nxt      = fcnt_r;
    now_nxt       = now_r;
    cur_nxt       = cur_r;
    per_nxt       = per_r;
    out_valid_nxt = out_valid_r && out_stall;
    stg_v_nxt     = stg_v_r;
    n_nxt         = n_r;
    op_nxt        = op_r;
    num_nxt       = num_r;
    hold_nxt      = hold_r;
    reps_nxt      = reps_r;
    e_nxt         = e_r;
    lk_nxt        = lk_r;
    dt_nxt        = dt_r;
    sl_nxt        = sl_r;
    sa_nxt        = sa_r;
    dsa_nxt       = dsa_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    lvl_nxt       = lvl_r;
    casc_nxt      = casc_r;
    fire_nxt      = fire_r;
    stg_nxt       = stg_r;
    em_nxt        = em_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    s_we          = 1'b0;
    s_wa          = sa_r;
    s_wd          = '0;
    s_ra          = sa_r;
    l_we          = 1'b0;
    l_wa          = e_r[IW-1:0];
    l_wd          = lk_r;
    l_ra          = e_r[IW-1:0];
    d_we          = 1'b0;
    d_wa          = e_r[IW-1:0];
    d_wd          = dt_r;
    d_ra          = e_r[IW-1:0];
    div_start     = 1'b0;

    if (cfg_valid) begin
      per_nxt = cfg_tick_period_ms;
    end

    unique case (state_r)
      // empty every slot and chain all entries into the free list
      ST_CLR: begin
        if (clr_r < CW'(SLOT_D)) begin
          s_we = 1'b1;
          s_wa = SA_W'(clr_r);
          s_wd = '{cnt: '0, head: NIL, tail: NIL};
        end
        if (clr_r < CW'(TIMER_ENTRIES)) begin
          l_we = 1'b1;
          l_wa = IW'(clr_r);
          l_wd = '{in_use: 1'b0, linked: 1'b0, lvl: '0, slot: '0,
                   prev: NIL, next: NIL, fnext: EW'(clr_r) + EW'(1)};
        end
        clr_nxt = clr_r + CW'(1);
        if (clr_r == CW'(CLR_N - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_operation;
          num_nxt  = in_timer_number;
          hold_nxt = in_hold_time_ms;
          reps_nxt = in_repeat_count;
          unique case (in_operation)
            OP_CREATE: state_nxt = ST_CR0;
            OP_TICK:   state_nxt = ST_TK0;
            default:   state_nxt = ST_CN0;
          endcase
        end
      end
      ST_CR0: begin
        if (fcnt_r == '0 || fhead_r >= NIL) begin
          stg_nxt   = '{kind: KIND_DONE, timer: '0, status: STAT_NO_FREE};
          stg_v_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          e_nxt     = fhead_r;
          l_ra      = fhead_r[IW-1:0];
          state_nxt = ST_CR1;
        end
      end
      ST_CR1: begin
        lk_nxt        = l_rd;
        lk_nxt.in_use = 1'b1;
        fhead_nxt     = l_rd.fnext;
        fcnt_nxt      = fcnt_r - EW'(1);
        div_start     = 1'b1;
        state_nxt     = ST_ARM_W;
      end
      ST_RS_ARM: begin
        div_start = 1'b1;
        state_nxt = ST_ARM_W;
      end
      ST_ARM_W: begin
        if (div_done) begin
          dt_nxt    = '{reps: reps_r, period: div_q, expiry: now_r + 64'(div_q)};
          d_we      = 1'b1;
          d_wd      = dt_nxt;
          ret_nxt   = ST_CMD_OK;
          state_nxt = ST_F0;
        end
      end
      ST_CN0: begin
        if (32'(num_r) >= 32'(TIMER_ENTRIES)) begin
          stg_nxt   = '{kind: KIND_DONE, timer: '0, status: STAT_BAD_ENTRY};
          stg_v_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          e_nxt     = EW'(num_r);
          l_ra      = IW'(num_r);
          state_nxt = ST_CN1;
        end
      end
      ST_CN1: begin
        lk_nxt = l_rd;
        if (!l_rd.in_use) begin
          stg_nxt   = '{kind: KIND_DONE, timer: 6'(e_r), status: STAT_NOT_ARMED};
          stg_v_nxt = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          ret_nxt   = (op_r == OP_CANCEL) ? ST_REL : ST_RS_ARM;
          state_nxt = ST_U0;
        end
      end
      // push the entry back on the free list
      ST_REL: begin
        lk_nxt.in_use = 1'b0;
        lk_nxt.fnext  = fhead_r;
        l_we          = 1'b1;
        l_wd          = lk_nxt;
        fhead_nxt     = e_r;
        fcnt_nxt      = fcnt_r + EW'(1);
        state_nxt     = (op_r == OP_TICK) ? ST_DR_NEXT : ST_CMD_OK;
      end
      ST_CMD_OK: begin
        stg_nxt   = '{kind: KIND_DONE, timer: 6'(e_r), status: STAT_OK};
        stg_v_nxt = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          if (stg_v_r) begin
            out_nxt = stg_r;
          end else begin
            out_nxt = '{kind: KIND_QUIET, timer: '0, status: STAT_OK};
          end
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          stg_v_nxt     = 1'b0;
          n_nxt         = '0;
          state_nxt     = ST_IDLE;
        end
      end
      // tick: advance time and fire the current level-0 slot
      ST_TK0: begin
        dsa_nxt    = SA_W'({{LVL_W{1'b0}}, cur_r[0]});
        now_nxt    = now_r + 64'd1;
        cur_nxt[0] = cur_r[0] + 8'd1;
        fire_nxt   = 1'b1;
        casc_nxt   = '0;
        state_nxt  = ST_DR0;
      end
      ST_DR0: begin
        s_ra      = dsa_r;
        state_nxt = ST_DR1;
      end
      ST_DR1: begin
        cnt_nxt   = s_rd.cnt;
        state_nxt = ST_DR2;
      end
      ST_DR2: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DR_END;
        end else begin
          s_ra      = dsa_r;
          state_nxt = ST_DR3;
        end
      end
      ST_DR3: begin
        if (s_rd.head >= NIL) begin
          state_nxt = ST_DR_END;
        end else begin
          e_nxt     = s_rd.head;
          l_ra      = s_rd.head[IW-1:0];
          d_ra      = s_rd.head[IW-1:0];
          state_nxt = ST_DR4;
        end
      end
      ST_DR4: begin
        lk_nxt    = l_rd;
        dt_nxt    = d_rd;
        ret_nxt   = ST_DR5;
        state_nxt = ST_U0;
      end
      ST_DR5: begin
        if (!fire_r) begin
          ret_nxt   = ST_DR_NEXT;
          state_nxt = ST_F0;
        end else begin
          em_nxt    = '{kind: KIND_EXPIRED, timer: 6'(e_r), status: STAT_OK};
          ret_nxt   = ST_DR6;
          state_nxt = ST_EMIT;
        end
      end
      // repeating entries move on by one period, the rest are freed
      ST_DR6: begin
        if (dt_r.reps >= REPEAT_FOREVER || dt_r.reps > 32'd1) begin
          if (dt_r.reps < REPEAT_FOREVER) begin
            dt_nxt.reps = dt_r.reps - 32'd1;
          end
          dt_nxt.expiry = dt_r.expiry + 64'(dt_r.period);
          d_we          = 1'b1;
          d_wd          = dt_nxt;
          ret_nxt       = ST_DR_NEXT;
          state_nxt     = ST_F0;
        end else begin
          state_nxt = ST_REL;
        end
      end
      ST_DR_NEXT: begin
        cnt_nxt   = cnt_r - EW'(1);
        state_nxt = ST_DR2;
      end
      // a cursor that wrapped to zero cascades the next level up
      ST_DR_END: begin
        if (cur_r[casc_r[LB-1:0]] == 8'd0 && casc_r < TOP_LVL) begin
          casc_nxt  = casc_r + LVL_W'(1);
          state_nxt = ST_CAS;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_CAS: begin
        dsa_nxt                     = SA_W'({casc_r, cur_r[casc_r[LB-1:0]]});
        cur_nxt[casc_r[LB-1:0]]     = cur_r[casc_r[LB-1:0]] + 8'd1;
        fire_nxt                    = 1'b0;
        state_nxt                   = ST_DR0;
      end
      // one-deep staging ahead of the output register; last flag set at the end
      ST_EMIT: begin
        if (n_r >= 7'(MAX_RESULTS)) begin
          state_nxt = ret_r;
        end else if (!stg_v_r) begin
          stg_nxt   = em_r;
          stg_v_nxt = 1'b1;
          n_nxt     = n_r + 7'd1;
          state_nxt = ret_r;
        end else if (out_free) begin
          out_nxt       = stg_r;
          out_last_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          stg_nxt       = em_r;
          n_nxt         = n_r + 7'd1;
          state_nxt     = ret_r;
        end
      end
      // unlink entry e_r from its slot list
      ST_U0: begin
        if (!lk_r.linked) begin
          state_nxt = ret_r;
        end else begin
          sa_nxt    = SA_W'({lk_r.lvl, lk_r.slot});
          s_ra      = sa_nxt;
          state_nxt = ST_U1;
        end
      end
      ST_U1: begin
        s_we      = 1'b1;
        s_wd.cnt  = s_rd.cnt - EW'(1);
        s_wd.head = (lk_r.prev < NIL) ? s_rd.head : lk_r.next;
        s_wd.tail = (lk_r.next < NIL) ? s_rd.tail : lk_r.prev;
        if (lk_r.prev < NIL) begin
          l_ra      = lk_r.prev[IW-1:0];
          state_nxt = ST_U2;
        end else begin
          state_nxt = ST_U3;
        end
      end
      ST_U2: begin
        l_wd      = l_rd;
        l_wd.next = lk_r.next;
        l_we      = 1'b1;
        l_wa      = lk_r.prev[IW-1:0];
        state_nxt = ST_U3;
      end
      ST_U3: begin
        if (lk_r.next < NIL) begin
          l_ra      = lk_r.next[IW-1:0];
          state_nxt = ST_U4;
        end else begin
          state_nxt = ST_U5;
        end
      end
      ST_U4: begin
        l_wd      = l_rd;
        l_wd.prev = lk_r.prev;
        l_we      = 1'b1;
        l_wa      = lk_r.next[IW-1:0];
        state_nxt = ST_U5;
      end
      ST_U5: begin
        lk_nxt.prev   = NIL;
        lk_nxt.next   = NIL;
        lk_nxt.linked = 1'b0;
        l_we          = 1'b1;
        l_wd          = lk_nxt;
        state_nxt     = ret_r;
      end
      // file entry e_r at the tail of the slot chosen by its remaining time
      ST_F0: begin
        rem_nxt   = rem_calc;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        lvl_nxt   = lv_cl;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        sa_nxt      = SA_W'({lvl_r, new_slot});
        s_ra        = sa_nxt;
        lk_nxt.lvl  = lvl_r;
        lk_nxt.slot = new_slot;
        state_nxt   = ST_F3;
      end
      ST_F3: begin
        sl_nxt    = s_rd;
        s_we      = 1'b1;
        s_wd.cnt  = s_rd.cnt + EW'(1);
        s_wd.head = (s_rd.tail < NIL) ? s_rd.head : e_r;
        s_wd.tail = e_r;
        if (s_rd.tail < NIL) begin
          l_ra      = s_rd.tail[IW-1:0];
          state_nxt = ST_F4;
        end else begin
          state_nxt = ST_F5;
        end
      end
      ST_F4: begin
        l_wd      = l_rd;
        l_wd.next = e_r;
        l_we      = 1'b1;
        l_wa      = sl_r.tail[IW-1:0];
        state_nxt = ST_F5;
      end
      ST_F5: begin
        lk_nxt.prev   = sl_r.tail;
        lk_nxt.next   = NIL;
        lk_nxt.linked = 1'b1;
        l_we          = 1'b1;
        l_wd          = lk_nxt;
        state_nxt     = ret_r;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      ret_r       <= ST_IDLE;
      clr_r       <= '0;
      fhead_r     <= '0;
      fcnt_r      <= EW'(TIMER_ENTRIES);
      now_r       <= '0;
      for (int i = 0; i < WHEEL_LEVELS; i++) begin
        cur_r[i] <= '0;
      end
      per_r       <= PER_RESET;
      out_valid_r <= 1'b0;
      stg_v_r     <= 1'b0;
      n_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      clr_r       <= clr_nxt;
      fhead_r     <= fhead_nxt;
      fcnt_r      <= fcnt_nxt;
      now_r       <= now_nxt;
      cur_r       <= cur_nxt;
      per_r       <= per_nxt;
      out_valid_r <= out_valid_nxt;
      stg_v_r     <= stg_v_nxt;
      n_r         <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    num_r      <= num_nxt;
    hold_r     <= hold_nxt;
    reps_r     <= reps_nxt;
    e_r        <= e_nxt;
    lk_r       <= lk_nxt;
    dt_r       <= dt_nxt;
    sl_r       <= sl_nxt;
    sa_r       <= sa_nxt;
    dsa_r      <= dsa_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    lvl_r      <= lvl_nxt;
    casc_r     <= casc_nxt;
    fire_r     <= fire_nxt;
    stg_r      <= stg_nxt;
    em_r       <= em_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = out_r.kind;
  assign out_result_timer = out_r.timer;
  assign out_status       = out_r.status;
  assign out_last_of_run  = out_last_r;

endmodule
